### src/thm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thm_pkg
// Shared types, constants and pixel tests of the text halo mask pass.
// ----------------------------------------------------------------------------
package thm_pkg;

	localparam int PIX_W         = 32;
	localparam int FW_W          = 12;
	localparam int FH_W          = 13;
	localparam int RW            = 12;
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_HEIGHT    = 4096;
	localparam int NSLOT         = 3;

	localparam logic [PIX_W-1:0] OPAQUE = 32'hFF00_0000;

	localparam logic [1:0] REG_HALO   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef struct packed {
		logic x_ge1;
		logic x_ge2;
		logic x_last;
		logic y_ge1;
		logic y_ge2;
		logic y_last;
	} pos_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             done;
	} res_t;

	typedef struct packed {
		res_t [NSLOT-1:0] slot;
		logic [1:0]       cnt;
	} res_set_t;

	function automatic logic mark(input logic v, input logic [PIX_W-1:0] p,
			input logic [PIX_W-1:0] halo);
		return v && (p != halo) && (p != '0);
	endfunction

	function automatic logic [PIX_W-1:0] shade(input logic [PIX_W-1:0] c,
			input logic [PIX_W-1:0] halo, input logic any_mark);
		logic [PIX_W-1:0] r;
		if (c != halo)
			r = c | OPAQUE;
		else if (any_mark)
			r = c;
		else
			r = '0;
		return r;
	endfunction

endpackage
`default_nettype wire

### src/text_halo_mask_pass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_halo_mask_pass
// Four-neighbour halo mask over a raster stream of ARGB pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock when the output does not stall. Each pixel is held in
// the input stage, where the two line stores are read at sequential addresses,
// and then loads the output register, from which its results are offered. Rows
// before the last give at most one result per pixel and run at one pixel per
// clock; on the last row a pixel gives up to two results (three at the last
// column) through the single output port, so the input is stalled there while
// the extra results of a pixel are handed out.
// ----------------------------------------------------------------------------
module text_halo_mask_pass import thm_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [PIX_W-1:0] cfg_wdata,
	input  wire logic             pix_valid,
	output logic                  pix_stall,
	input  wire logic [PIX_W-1:0] pixel_in,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic      [PIX_W-1:0] pixel_out,
	output logic                  last_in_run,
	output logic                  frame_done
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

	logic [PIX_W-1:0] halo_q;
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;

	logic [EW-1:0]    fw_ext, w_eff, w_eff_m1;
	logic [CW-1:0]    w_last;
	logic [FH_W-1:0]  fh_m1;
	logic [RW-1:0]    h_last;
	logic [PIX_W-1:0] halo;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;

	logic             s1_valid;
	logic [PIX_W-1:0] p_s1;
	logic [CW-1:0]    x_s1;
	pos_t             pos_s1;

	logic [PIX_W-1:0] a_left_q, a_cur_q, col0_q, prev1_q, prev2_q;
	logic [PIX_W-1:0] a_rd, b_rd;

	logic             acc, adv, q_free;
	pos_t             pos_in;
	res_set_t         set;

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halo_q <= OPAQUE;
			fw_q   <= FW_W'(2048);
			fh_q   <= FH_W'(16);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_HALO:   halo_q <= cfg_wdata;
				REG_WIDTH:  fw_q   <= cfg_wdata[FW_W-1:0];
				REG_HEIGHT: fh_q   <= cfg_wdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		fw_ext = EW'(fw_q);
		if (fw_ext == '0)
			w_eff = EW'(1);
		else if (fw_ext > EW'(MAX_WIDTH))
			w_eff = EW'(MAX_WIDTH);
		else
			w_eff = fw_ext;
		w_eff_m1 = w_eff - EW'(1);
		w_last   = w_eff_m1[CW-1:0];

		fh_m1 = fh_q - FH_W'(1);
		if (fh_q == '0)
			h_last = '0;
		else if (fh_q > FH_W'(MAX_HEIGHT))
			h_last = RW'(MAX_HEIGHT - 1);
		else
			h_last = fh_m1[RW-1:0];
	end

	assign halo = halo_q | OPAQUE;

	// ---- handshake ----
	assign pix_stall = s1_valid && !q_free;
	assign acc       = pix_valid && !pix_stall;
	assign adv       = s1_valid && q_free;

	// ---- position ----
	always_comb begin
		pos_in.x_ge1  = (col_q != '0);
		pos_in.x_ge2  = (col_q > CW'(1));
		pos_in.x_last = (col_q == w_last);
		pos_in.y_ge1  = (row_q != '0);
		pos_in.y_ge2  = (row_q > RW'(1));
		pos_in.y_last = (row_q == h_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wen && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (pos_in.x_last) begin
				col_q <= '0;
				row_q <= pos_in.y_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---- input stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (acc)
			s1_valid <= 1'b1;
		else if (adv)
			s1_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			p_s1   <= pixel_in;
			x_s1   <= col_q;
			pos_s1 <= pos_in;
		end
	end

	// neighbour window along the row above and the current row
	always_ff @(posedge clk) begin
		if (adv) begin
			a_left_q <= a_cur_q;
			a_cur_q  <= pos_s1.x_last ? (pos_s1.x_ge1 ? col0_q : p_s1) : a_rd;
			prev1_q  <= p_s1;
			prev2_q  <= prev1_q;
			if (!pos_s1.x_ge1)
				col0_q <= p_s1;
		end
	end

	// row y-1, read one column ahead
	thm_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_row_one (
		.clk   (clk),
		.we    (adv),
		.waddr (x_s1),
		.wdata (p_s1),
		.re    (acc),
		.raddr (col_q + CW'(1)),
		.rdata (a_rd)
	);

	// row y-2
	thm_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_row_two (
		.clk   (clk),
		.we    (adv),
		.waddr (x_s1),
		.wdata (a_cur_q),
		.re    (acc),
		.raddr (col_q),
		.rdata (b_rd)
	);

	thm_kernel u_kernel (
		.p       (p_s1),
		.a_left  (a_left_q),
		.a_cur   (a_cur_q),
		.a_right (a_rd),
		.a_up    (b_rd),
		.prev1   (prev1_q),
		.prev2   (prev2_q),
		.halo    (halo),
		.pos     (pos_s1),
		.set     (set)
	);

	thm_result_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (adv),
		.set         (set),
		.free        (q_free),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.pixel_out   (pixel_out),
		.last_in_run (last_in_run),
		.frame_done  (frame_done)
	);

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last)
		else $error("column count past row end");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_last)
		else $error("row count past frame end");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> s1_valid)
		else $error("input stalled with empty input stage");

endmodule
`default_nettype wire

### src/thm_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thm_line_store
// One row of pixels, one write and one registered write-first read per cycle.
// ----------------------------------------------------------------------------
module thm_line_store import thm_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [PIX_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr))
				rdata <= wdata;
			else
				rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### src/thm_kernel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thm_kernel
// Neighbour tests for one input pixel and packing of its up to three results.
// ----------------------------------------------------------------------------
module thm_kernel import thm_pkg::*; (
	input  wire logic [PIX_W-1:0] p,
	input  wire logic [PIX_W-1:0] a_left,
	input  wire logic [PIX_W-1:0] a_cur,
	input  wire logic [PIX_W-1:0] a_right,
	input  wire logic [PIX_W-1:0] a_up,
	input  wire logic [PIX_W-1:0] prev1,
	input  wire logic [PIX_W-1:0] prev2,
	input  wire logic [PIX_W-1:0] halo,
	input  wire pos_t             pos,
	output res_set_t              set
);

	logic [PIX_W-1:0] r0, r1, r2;
	logic             en0, en1, en2;

	always_comb begin
		// pixel above the current one, finished now that its lower neighbour is here
		r0 = shade(a_cur, halo,
			mark(pos.x_ge1, a_left, halo) || mark(!pos.x_last, a_right, halo) ||
			mark(pos.y_ge2, a_up, halo) || mark(1'b1, p, halo));
		// last row: left neighbour of the current pixel
		r1 = shade(prev1, halo,
			mark(pos.x_ge2, prev2, halo) || mark(1'b1, p, halo) ||
			mark(pos.y_ge1, a_left, halo));
		// last row, last column: the current pixel itself
		r2 = shade(p, halo,
			mark(pos.x_ge1, prev1, halo) || mark(pos.y_ge1, a_cur, halo));

		en0 = pos.y_ge1;
		en1 = pos.y_last && pos.x_ge1;
		en2 = pos.y_last && pos.x_last;

		set.slot[0].pix  = en0 ? r0 : (en1 ? r1 : r2);
		set.slot[0].done = !en0 && !en1;
		set.slot[1].pix  = (en0 && en1) ? r1 : r2;
		set.slot[1].done = !(en0 && en1);
		set.slot[2].pix  = r2;
		set.slot[2].done = 1'b1;
		set.cnt = {1'b0, en0} + {1'b0, en1} + {1'b0, en2};
	end

endmodule
`default_nettype wire

### src/thm_result_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thm_result_queue
// Output register holding the results of one pixel, handed out one per cycle while res_stall is low.
// ----------------------------------------------------------------------------
module thm_result_queue import thm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire res_set_t         set,
	output logic                  free,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic      [PIX_W-1:0] pixel_out,
	output logic                  last_in_run,
	output logic                  frame_done
);

	res_t [NSLOT-1:0] slot_q;
	logic [1:0]       cnt_q;
	logic [1:0]       idx_q;
	res_t             head;
	logic             take;

	assign res_valid   = (cnt_q != 2'd0);
	assign head        = slot_q[idx_q];
	assign pixel_out   = head.pix;
	assign frame_done  = head.done;
	assign last_in_run = (idx_q == 2'(cnt_q - 2'd1));
	assign take        = res_valid && !res_stall;
	assign free        = !res_valid || (take && last_in_run);

	always_ff @(posedge clk) begin
		if (load)
			slot_q <= set.slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= set.cnt;
			idx_q <= 2'd0;
		end else if (take) begin
			if (last_in_run) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (idx_q < cnt_q))
		else $error("result index beyond result count");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> (idx_q == 2'd0))
		else $error("result index not cleared when empty");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_done) |-> last_in_run)
		else $error("frame end not on last result of its transaction");

endmodule
`default_nettype wire

### sim/text_halo_mask_pass_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_halo_mask_pass_tb
// Self-checking testbench for the four-neighbour halo mask pass.
// ----------------------------------------------------------------------------
// A short directed run covers the register defaults, width and height of zero,
// an unused register index, a halo change inside a frame and a frame that is
// cut off by new geometry. The start of a frame at the widest row follows,
// then random frames of small geometry with halo-heavy content. Now and then a
// frame uses oversized geometry and is cut off. Both channels idle and stall
// at random. A scoreboard tracks the line stores and the frame position,
// predicts every output pixel and checks the output stream field by field.
// ----------------------------------------------------------------------------
module text_halo_mask_pass_tb;
	import thm_pkg::*;

	localparam logic [1:0] REG_SPARE   = 2'd3;
	localparam int         SETTLE      = 8;
	localparam int         STUCK_LIMIT = 2000;
	localparam int         RANDOM_ITEMS = 170;
	localparam int         WIDE_ITEMS   = 30;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             ends_run;
		logic             ends_frame;
	} halo_result_t;

	class halo_mask_board;
		logic [PIX_W-1:0] halo_reg;
		logic [FW_W-1:0]  width_reg;
		logic [FH_W-1:0]  height_reg;
		logic [PIX_W-1:0] line_two [MAX_WIDTH_DEF];
		logic [PIX_W-1:0] line_one [MAX_WIDTH_DEF];
		logic [PIX_W-1:0] left1, left2;
		int unsigned      col, row;
		halo_result_t     pending [$];
		int               errors;

		function new();
			halo_reg   = OPAQUE;
			width_reg  = 12'd2048;
			height_reg = 13'd16;
			foreach (line_two[i]) begin
				line_two[i] = '0;
				line_one[i] = '0;
			end
			errors = 0;
			restart();
		endfunction

		function void restart();
			col   = 0;
			row   = 0;
			left1 = '0;
			left2 = '0;
		endfunction

		function int unsigned eff_w();
			if (width_reg == 0)
				return 1;
			if (width_reg > MAX_WIDTH_DEF)
				return MAX_WIDTH_DEF;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			if (height_reg == 0)
				return 1;
			if (height_reg > MAX_HEIGHT)
				return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void write_reg(logic [1:0] idx, logic [PIX_W-1:0] val);
			case (idx)
				REG_HALO: begin
					halo_reg = val;
				end
				REG_WIDTH: begin
					width_reg = val[FW_W-1:0];
					restart();
				end
				REG_HEIGHT: begin
					height_reg = val[FH_W-1:0];
					restart();
				end
				default: begin
				end
			endcase
		endfunction

		function bit marked(bit ok, logic [PIX_W-1:0] p, logic [PIX_W-1:0] hc);
			return ok && (p != hc) && (p != '0);
		endfunction

		function logic [PIX_W-1:0] masked(logic [PIX_W-1:0] c, logic [PIX_W-1:0] hc,
				bit any_mark);
			if (c != hc)
				return c | OPAQUE;
			return any_mark ? c : '0;
		endfunction

		function void expect_pixel(logic [PIX_W-1:0] v, logic fin);
			halo_result_t r;
			r.pix        = v;
			r.ends_run   = 1'b0;
			r.ends_frame = fin;
			pending.push_back(r);
		endfunction

		// One accepted input transaction: predict its output pixels, update stores.
		function void note_pixel(logic [PIX_W-1:0] p);
			int unsigned      w, h, x, y, first;
			logic [PIX_W-1:0] hc, lft, rgt;
			bit               rv, any;
			w  = eff_w();
			h  = eff_h();
			hc = halo_reg | OPAQUE;
			if (col >= w || row >= h)
				restart();
			x     = col;
			y     = row;
			first = pending.size();
			if (y >= 1) begin
				rv  = (x + 1) < w;
				lft = (x > 0) ? line_two[x-1] : '0;
				rgt = rv ? line_one[x+1] : '0;
				any = marked(x > 0, lft, hc) || marked(rv, rgt, hc) ||
					marked(y >= 2, line_two[x], hc) || marked(1'b1, p, hc);
				expect_pixel(masked(line_one[x], hc, any), 1'b0);
			end
			if (y == h - 1) begin
				if (x >= 1) begin
					any = marked(x >= 2, left2, hc) || marked(1'b1, p, hc) ||
						marked(y >= 1, line_two[x-1], hc);
					expect_pixel(masked(left1, hc, any), 1'b0);
				end
				if (x == w - 1) begin
					any = marked(x >= 1, left1, hc) || marked(y >= 1, line_one[x], hc);
					expect_pixel(masked(p, hc, any), 1'b1);
				end
			end
			line_two[x] = line_one[x];
			line_one[x] = p;
			left2 = left1;
			left1 = p;
			if (x + 1 >= w) begin
				col   = 0;
				left1 = '0;
				left2 = '0;
				row   = (y + 1 >= h) ? 0 : y + 1;
			end else begin
				col = x + 1;
			end
			if (pending.size() > first)
				pending[pending.size()-1].ends_run = 1'b1;
		endfunction

		function void match_result(logic [PIX_W-1:0] pix, logic run_end, logic frm_end);
			halo_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected transaction: pixel_out=%h", pix);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (pix !== e.pix) begin
				$error("pixel_out: expected %h, actual %h", e.pix, pix);
				errors++;
			end
			if (run_end !== e.ends_run) begin
				$error("last_in_run: expected %b, actual %b", e.ends_run, run_end);
				errors++;
			end
			if (frm_end !== e.ends_frame) begin
				$error("frame_done: expected %b, actual %b", e.ends_frame, frm_end);
				errors++;
			end
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_wen   = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [PIX_W-1:0] cfg_wdata = '0;
	logic             pix_valid = 1'b0;
	logic             pix_stall;
	logic [PIX_W-1:0] pixel_in  = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [PIX_W-1:0] pixel_out;
	logic             last_in_run;
	logic             frame_done;

	bit               quiet = 1'b0;
	int               stuck_cycles = 0;
	int               random_sent = 0;
	halo_mask_board   board;

	text_halo_mask_pass i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pixel_in    (pixel_in),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.pixel_out   (pixel_out),
		.last_in_run (last_in_run),
		.frame_done  (frame_done)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		res_stall <= !quiet && ($urandom_range(99) < 30);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				board.match_result(pixel_out, last_in_run, frame_done);
			if (pix_valid && !pix_stall)
				board.note_pixel(pixel_in);
			if ((res_valid && !res_stall) || (pix_valid && !pix_stall) || cfg_wen) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	function automatic int idle_len();
		int n;
		n = 0;
		if (quiet)
			return 0;
		while ($urandom_range(99) < 30)
			n++;
		return n;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(int halo_pct);
		int r;
		r = $urandom_range(99);
		if (r < halo_pct)
			return board.halo_reg | OPAQUE;
		if (r < halo_pct + 10)
			return '0;
		if (r < halo_pct + 14)
			return board.halo_reg;
		if (r < halo_pct + 17)
			return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	task automatic send_pixel(logic [PIX_W-1:0] p);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_in  <= p;
		do @(posedge clk); while (pix_stall);
	endtask

	// Hold the sender until every predicted pixel has been delivered.
	task automatic quiesce();
		pix_valid <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [PIX_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		board.write_reg(idx, val);
	endtask

	task automatic set_geometry(logic [PIX_W-1:0] hv, logic [FW_W-1:0] w,
			logic [FH_W-1:0] h);
		quiesce();
		cfg_write(REG_HALO, hv);
		cfg_write(REG_WIDTH, ($urandom() << FW_W) | w);
		cfg_write(REG_HEIGHT, ($urandom() << FH_W) | h);
		if ($urandom_range(1))
			cfg_write(REG_SPARE, $urandom());
		cfg_wen <= 1'b0;
	endtask

	task automatic random_phase(int phase_no);
		logic [FW_W-1:0]  w;
		logic [FH_W-1:0]  h;
		logic [PIX_W-1:0] hv;
		int               n, pct;
		quiet = (phase_no % 5 == 2);
		hv    = ($urandom_range(3) == 0) ? '0 : $urandom();
		pct   = $urandom_range(20, 75);
		if ($urandom_range(9) == 0) begin
			if ($urandom_range(1)) begin
				case ($urandom_range(3))
					0: w = 12'd2047;
					1: w = 12'd2048;
					2: w = 12'd2049;
					default: w = 12'hFFF;
				endcase
				h = FH_W'($urandom_range(1, 3));
			end else begin
				w = FW_W'($urandom_range(1, 3));
				case ($urandom_range(3))
					0: h = 13'd4096;
					1: h = 13'd4097;
					2: h = 13'h1FFF;
					default: h = 13'd0;
				endcase
			end
			set_geometry(hv, w, h);
			n = $urandom_range(4, 24);
		end else begin
			w = FW_W'($urandom_range(1, 7));
			h = FH_W'($urandom_range(1, 6));
			set_geometry(hv, w, h);
			n = board.eff_w() * board.eff_h() * $urandom_range(1, 2) +
				$urandom_range(0, board.eff_w());
		end
		repeat (n) begin
			if ($urandom_range(39) == 0)
				quiesce();
			send_pixel(pick_pixel(pct));
			random_sent++;
		end
	endtask

	initial begin
		int phase_no;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults for the halo colour, then a 3x2 frame
		cfg_write(REG_WIDTH, 32'd3);
		cfg_write(REG_HEIGHT, 32'd2);
		cfg_wen <= 1'b0;
		send_pixel(32'hFF00_0000);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFF00_0000);
		send_pixel(32'hFF00_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFF00_0000);

		// zero width and height act as single-pixel frames
		set_geometry(32'hFFFF_FFFF, '0, '0);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h00FF_FFFF);
		send_pixel(32'h0000_0000);

		// halo colour rewritten in the middle of a frame
		set_geometry(32'h1234_5678, 12'd2, 13'd3);
		send_pixel(32'hFF34_5678);
		send_pixel(32'h1234_5678);
		send_pixel(32'h0000_0001);
		quiesce();
		cfg_write(REG_HALO, 32'h00AB_CDEF);
		cfg_wen <= 1'b0;
		send_pixel(32'hFFAB_CDEF);
		send_pixel(32'hFFAB_CDEF);
		send_pixel(32'h0000_0000);

		// oversized height, frame cut off by the next geometry write
		set_geometry(32'h0000_0000, 12'd4, 13'h1FFF);
		repeat (6) send_pixel(pick_pixel(50));

		// start of a frame at the widest row, width register above the limit
		set_geometry(32'h8000_0080, 12'hFFF, 13'd2);
		repeat (WIDE_ITEMS) send_pixel(pick_pixel(55));

		phase_no = 0;
		while (random_sent < RANDOM_ITEMS) begin
			random_phase(phase_no);
			phase_no++;
		end

		quiet = 1'b0;
		quiesce();
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
src/thm_pkg.sv
src/thm_line_store.sv
src/thm_kernel.sv
src/thm_result_queue.sv
src/text_halo_mask_pass.sv
sim/text_halo_mask_pass_tb.sv
